// ===== src/ptc_pkg.sv =====
package ptc_pkg;

	localparam int unsigned NUM_TRIM = 6;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned DIV_STAGES = 32;

	localparam logic [31:0] OFFSET_TFINE = 32'd64000;
	localparam logic [31:0] PRESS_BASE = 32'd1048576;
	localparam logic [31:0] PRESS_SCALE = 32'd3125;
	localparam logic [31:0] SPLIT_LIMIT = 32'h8000_0000;
	localparam logic [31:0] DIV_BASE = 32'd32768;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_T1_T2 = 3'd0,
		REG_T3_P1 = 3'd1,
		REG_P2_P3 = 3'd2,
		REG_P4_P5 = 3'd3,
		REG_P6_P7 = 3'd4,
		REG_P8_P9 = 3'd5
	} ptc_reg_t;

	typedef struct packed {
		logic [19:0] raw_pressure;
		logic [19:0] raw_temperature;
	} ptc_in_t;

	typedef struct packed {
		logic [31:0] pressure_pa;
		logic signed [31:0] fine_temperature;
		logic divisor_zero;
	} ptc_out_t;

	// trim words, each widened to 32 bits
	typedef struct packed {
		logic [31:0] t1;
		logic [31:0] t2;
		logic [31:0] t3;
		logic [31:0] p1;
		logic [31:0] p2;
		logic [31:0] p3;
		logic [31:0] p4;
		logic [31:0] p5;
		logic [31:0] p6;
		logic [31:0] p7;
		logic [31:0] p8;
		logic [31:0] p9;
	} ptc_trim_t;

	// word handed from front to back through the queue
	typedef struct packed {
		logic [31:0] dividend;
		logic [31:0] divisor;
		logic split;
		logic zero;
		logic [31:0] tfine;
	} ptc_div_t;

	function automatic logic [31:0] sar(input logic [31:0] v, input int unsigned s);
		return $unsigned($signed(v) >>> s);
	endfunction

	function automatic logic [31:0] sext16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	// one restoring divide step: returns {remainder, shifted dividend/quotient}
	function automatic logic [63:0] div_step(input logic [31:0] rem, input logic [31:0] dq,
			input logic [31:0] den);
		logic [32:0] r;
		logic ge;
		logic [32:0] diff;
		r = {rem, dq[31]};
		diff = r - {1'b0, den};
		ge = (r >= {1'b0, den});
		return {(ge ? diff[31:0] : r[31:0]), dq[30:0], ge};
	endfunction

endpackage

// ===== src/ptc_front.sv =====
module ptc_front import ptc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input ptc_in_t item,
	input ptc_trim_t trim,
	output logic out_valid,
	output ptc_div_t out_word
);

	logic [6:0] v_q;

	logic [31:0] m1_s1, dd_s1;
	logic [19:0] adcp_s1, adcp_s2, adcp_s3, adcp_s4, adcp_s5;
	logic [31:0] tfine_s2, tfine_s3, tfine_s4, tfine_s5, tfine_s6;
	logic [31:0] sq_s3, ap5_s3, p2a_s3;
	logic [31:0] b0_s4, c_s4, ap5_s4, p2a_s4;
	logic [31:0] b_s5, av_s5;
	logic [31:0] den_s6, num_s6;
	ptc_div_t word_s7;

	logic [31:0] adc_t, d, a3, q3, b5, av5, num6;

	assign adc_t = {12'd0, item.raw_temperature};
	assign d = (adc_t >> 4) - trim.t1;
	assign a3 = sar(tfine_s2, 1) - OFFSET_TFINE;
	assign q3 = sar(a3, 2);
	assign b5 = sar(b0_s4 + (ap5_s4 << 1), 2) + (trim.p4 << 16);
	assign av5 = sar(sar(c_s4, 3) + sar(p2a_s4, 1), 18);
	assign num6 = ((PRESS_BASE - {12'd0, adcp_s5}) - sar(b_s5, 12)) * PRESS_SCALE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[5:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m1_s1 <= ((adc_t >> 3) - (trim.t1 << 1)) * trim.t2;
			dd_s1 <= d * d;
			adcp_s1 <= item.raw_pressure;

			tfine_s2 <= sar(m1_s1, 11) + sar(sar(dd_s1, 12) * trim.t3, 14);
			adcp_s2 <= adcp_s1;

			sq_s3 <= q3 * q3;
			ap5_s3 <= a3 * trim.p5;
			p2a_s3 <= trim.p2 * a3;
			tfine_s3 <= tfine_s2;
			adcp_s3 <= adcp_s2;

			b0_s4 <= sar(sq_s3, 11) * trim.p6;
			c_s4 <= trim.p3 * sar(sq_s3, 13);
			ap5_s4 <= ap5_s3;
			p2a_s4 <= p2a_s3;
			tfine_s4 <= tfine_s3;
			adcp_s4 <= adcp_s3;

			b_s5 <= b5;
			av_s5 <= av5;
			tfine_s5 <= tfine_s4;
			adcp_s5 <= adcp_s4;

			den_s6 <= sar((DIV_BASE + av_s5) * trim.p1, 15);
			num_s6 <= num6;
			tfine_s6 <= tfine_s5;

			// below the split limit the doubled value still fits in 32 bits
			word_s7.split <= (num_s6 >= SPLIT_LIMIT);
			word_s7.dividend <= (num_s6 >= SPLIT_LIMIT) ? num_s6 : (num_s6 << 1);
			word_s7.divisor <= den_s6;
			word_s7.zero <= (den_s6 == '0);
			word_s7.tfine <= tfine_s6;
		end
	end

	assign out_valid = v_q[6] & en;
	assign out_word = word_s7;

endmodule

// ===== src/ptc_queue.sv =====
module ptc_queue import ptc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input ptc_div_t push_word,
	input logic pop,
	output ptc_div_t pop_word,
	output logic full,
	output logic empty
);

	localparam int unsigned DEPTH = 4;
	localparam int unsigned PW = $clog2(DEPTH);

	ptc_div_t mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0] cnt_q;

	assign full = (cnt_q == (PW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign pop_word = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_word;
	end

endmodule

// ===== src/ptc_back.sv =====
module ptc_back import ptc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input ptc_div_t in_word,
	input ptc_trim_t trim,
	output logic done,
	output ptc_out_t result
);

	logic [DIV_STAGES-1:0] v_q;
	logic [31:0] rem_q [DIV_STAGES];
	logic [31:0] dq_q [DIV_STAGES];
	logic [31:0] den_q [DIV_STAGES];
	logic [31:0] tf_q [DIV_STAGES];
	logic split_q [DIV_STAGES];
	logic zero_q [DIV_STAGES];

	logic v_s1, v_s2, v_s3;
	logic [31:0] press_s1, w_s1, bp8_s1, tf_s1;
	logic zero_s1;
	logic [31:0] press_s2, a_s2, b_s2, tf_s2;
	logic zero_s2;
	ptc_out_t res_s3;

	logic [31:0] quo, press1, fin;

	assign quo = dq_q[DIV_STAGES-1];
	assign press1 = split_q[DIV_STAGES-1] ? {quo[30:0], 1'b0} : quo;
	assign fin = press_s2 + sar(a_s2 + b_s2 + trim.p7, 4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_q <= {v_q[DIV_STAGES-2:0], in_valid};
			v_s1 <= v_q[DIV_STAGES-1];
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// one quotient bit per stage
	always_ff @(posedge clk) begin
		{rem_q[0], dq_q[0]} <= div_step('0, in_word.dividend, in_word.divisor);
		den_q[0] <= in_word.divisor;
		tf_q[0] <= in_word.tfine;
		split_q[0] <= in_word.split;
		zero_q[0] <= in_word.zero;
		for (int i = 1; i < DIV_STAGES; i++) begin
			{rem_q[i], dq_q[i]} <= div_step(rem_q[i-1], dq_q[i-1], den_q[i-1]);
			den_q[i] <= den_q[i-1];
			tf_q[i] <= tf_q[i-1];
			split_q[i] <= split_q[i-1];
			zero_q[i] <= zero_q[i-1];
		end

		press_s1 <= press1;
		w_s1 <= (press1 >> 3) * (press1 >> 3);
		bp8_s1 <= (press1 >> 2) * trim.p8;
		tf_s1 <= tf_q[DIV_STAGES-1];
		zero_s1 <= zero_q[DIV_STAGES-1];

		press_s2 <= press_s1;
		a_s2 <= sar(trim.p9 * (w_s1 >> 13), 12);
		b_s2 <= sar(bp8_s1, 13);
		tf_s2 <= tf_s1;
		zero_s2 <= zero_s1;

		res_s3.pressure_pa <= zero_s2 ? '0 : fin;
		res_s3.fine_temperature <= $signed(tf_s2);
		res_s3.divisor_zero <= zero_s2;
	end

	assign done = v_s3;
	assign result = res_s3;

endmodule

// ===== src/pressure_temperature_compensation.sv =====
// Integer barometric compensation: each word of raw pressure and temperature gives one result
// word with pressure in pascals, fine temperature and a zero-divisor flag. A new word is taken
// every clock while busy is low; it passes 7 front stages and the queue, then a 32-stage
// divider (one quotient bit per stage) and 3 output stages. The result is shown for a single
// cycle on done and cannot be held off. busy only rises if the queue fills. The user must write
// trim registers via the cfg port only while no word is in flight; the block does not check.
module pressure_temperature_compensation import ptc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input ptc_in_t item,
	output logic done,
	output ptc_out_t result,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [31:0] cfg_data
);

	logic [31:0] trim_q [NUM_TRIM];
	ptc_trim_t trim;
	logic q_push, q_pop, q_full, q_empty, front_en;
	ptc_div_t front_word, back_word;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TRIM; i++) trim_q[i] <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_T1_T2: trim_q[0] <= cfg_data;
				REG_T3_P1: trim_q[1] <= cfg_data;
				REG_P2_P3: trim_q[2] <= cfg_data;
				REG_P4_P5: trim_q[3] <= cfg_data;
				REG_P6_P7: trim_q[4] <= cfg_data;
				REG_P8_P9: trim_q[5] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		trim.t1 = {16'd0, trim_q[0][15:0]};
		trim.t2 = sext16(trim_q[0][31:16]);
		trim.t3 = sext16(trim_q[1][15:0]);
		trim.p1 = {16'd0, trim_q[1][31:16]};
		trim.p2 = sext16(trim_q[2][15:0]);
		trim.p3 = sext16(trim_q[2][31:16]);
		trim.p4 = sext16(trim_q[3][15:0]);
		trim.p5 = sext16(trim_q[3][31:16]);
		trim.p6 = sext16(trim_q[4][15:0]);
		trim.p7 = sext16(trim_q[4][31:16]);
		trim.p8 = sext16(trim_q[5][15:0]);
		trim.p9 = sext16(trim_q[5][31:16]);
	end

	// front holds while the queue is full
	assign front_en = !q_full;
	assign busy = q_full;
	assign q_pop = !q_empty;

	ptc_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.en(front_en),
		.in_valid(start && !busy),
		.item(item),
		.trim(trim),
		.out_valid(q_push),
		.out_word(front_word)
	);

	ptc_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_word(front_word),
		.pop(q_pop),
		.pop_word(back_word),
		.full(q_full),
		.empty(q_empty)
	);

	ptc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(q_pop),
		.in_word(back_word),
		.trim(trim),
		.done(done),
		.result(result)
	);

	a_zero_press: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.divisor_zero |-> result.pressure_pa == '0)
		else $error("zero divisor gave nonzero pressure");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("queue read while empty");

endmodule
